### src/fp32_add_sub_core_assert.svh
// Assertion macros used by the checker file.
`ifndef FP32_ADD_SUB_CORE_ASSERT_SVH
`define FP32_ADD_SUB_CORE_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define FAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### src/fas_pkg.sv
// Package with shared constants and types of the single-precision adder.
`timescale 1ns / 1ps
`default_nettype none
package fas_pkg;
	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_SUB = 1'b1;
	localparam logic [31:0] INF_BITS = 32'h7F80_0000;
	typedef logic [31:0] word_t;
endpackage
`default_nettype wire

### src/fp32_add_sub_core.sv
// Pipeline: four stages; an accepted item moves through stage 1, 2, 3 and 4 registers; stage 4 drives the outputs.
// Throughput: one item per cycle without stalls; each stage moves on when the stage after it can take its item.
// A stall on the output holds the full stages behind it while empty stages keep filling.
// Reset clears all stage valid bits; data registers are not reset.
// The normalize step uses a leading-zero count over the 24-bit difference.
`timescale 1ns / 1ps
`default_nettype none
module fp32_add_sub_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          func,
	input  wire fas_pkg::word_t operand_a,
	input  wire fas_pkg::word_t operand_b,
	output logic               out_valid,
	input  wire logic          out_ready,
	output fas_pkg::word_t     sum_bits
);
	import fas_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// Stage 1 data
	logic        bypass_s1, same_s1, sign_s1;
	word_t       byp_s1;
	logic [7:0]  e_big_s1;
	logic [23:0] f_big_s1, f_small_s1;
	logic [4:0]  sh_s1;
	// Stage 2 data
	logic        bypass_s2, same_s2, sign_s2;
	word_t       byp_s2;
	logic [7:0]  e_s2;
	logic [24:0] m_s2;
	// Stage 3 data
	logic        bypass_s3, same_s3, sign_s3;
	word_t       byp_s3;
	logic [7:0]  e_s3;
	logic [24:0] m_s3;
	logic [4:0]  lz_s3;
	word_t       res_s4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;
	assign sum_bits = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: unpack, order operands, shift amount.
	word_t       b_eff;
	logic [7:0]  ea, eb;
	logic [23:0] fa, fb;
	logic        b_larger;
	logic [7:0]  ediff;
	always_comb begin
		b_eff = (func == FUNC_SUB) ? (operand_b ^ 32'h8000_0000) : operand_b;
		ea = operand_a[30:23];
		eb = b_eff[30:23];
		fa = {1'b1, operand_a[22:0]};
		fb = {1'b1, b_eff[22:0]};
		b_larger = (ea != eb) ? (eb > ea) : (fb > fa);
		ediff = b_larger ? (eb - ea) : (ea - eb);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			bypass_s1 <= (operand_a[30:0] == 31'd0) || (b_eff[30:0] == 31'd0);
			byp_s1 <= (operand_a[30:0] == 31'd0) ? b_eff : operand_a;
			same_s1 <= operand_a[31] == b_eff[31];
			sign_s1 <= b_larger ? b_eff[31] : operand_a[31];
			e_big_s1 <= b_larger ? eb : ea;
			f_big_s1 <= b_larger ? fb : fa;
			f_small_s1 <= b_larger ? fa : fb;
			sh_s1 <= (ediff > 8'd31) ? 5'd31 : ediff[4:0];
		end
	end

	// Stage 2: align and add or subtract.
	logic [23:0] aligned;
	assign aligned = f_small_s1 >> sh_s1;
	always_ff @(posedge clk) begin
		if (en2) begin
			bypass_s2 <= bypass_s1;
			byp_s2 <= byp_s1;
			same_s2 <= same_s1;
			sign_s2 <= sign_s1;
			e_s2 <= e_big_s1;
			m_s2 <= same_s1 ? ({1'b0, f_big_s1} + {1'b0, aligned})
				: ({1'b0, f_big_s1} - {1'b0, aligned});
		end
	end

	// Stage 3: leading-zero count of the difference.
	logic [4:0] lz;
	always_comb begin
		lz = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (m_s2[i]) lz = 5'(23 - i);
		end
	end
	always_ff @(posedge clk) begin
		if (en3) begin
			bypass_s3 <= bypass_s2;
			byp_s3 <= byp_s2;
			same_s3 <= same_s2;
			sign_s3 <= sign_s2;
			e_s3 <= e_s2;
			m_s3 <= m_s2;
			lz_s3 <= lz;
		end
	end

	// Stage 4: normalize and pack.
	logic [8:0]  e_inc;
	logic [4:0]  nsh;
	logic [23:0] mn;
	word_t       res;
	always_comb begin
		e_inc = {1'b0, e_s3} + 9'd1;
		nsh = ({3'b0, lz_s3} > e_s3) ? e_s3[4:0] : lz_s3;
		mn = m_s3[23:0] << nsh;
		if (bypass_s3) begin
			res = byp_s3;
		end else if (same_s3) begin
			if (m_s3[24]) begin
				if (e_inc >= 9'd255) res = {sign_s3, INF_BITS[30:0]};
				else res = {sign_s3, e_inc[7:0], m_s3[23:1]};
			end else if (e_s3 == 8'd255) begin
				res = {sign_s3, INF_BITS[30:0]};
			end else begin
				res = {sign_s3, e_s3, m_s3[22:0]};
			end
		end else if (m_s3[23:0] == 24'd0) begin
			res = 32'd0;
		end else begin
			res = {sign_s3, e_s3 - {3'b0, nsh}, mn[22:0]};
		end
	end
	always_ff @(posedge clk) begin
		if (en4) res_s4 <= res;
	end
endmodule
`default_nettype wire

### src/fp32_add_sub_core_checker.sv
// Port-level checker for the single-precision adder, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "fp32_add_sub_core_assert.svh"
module fp32_add_sub_core_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire fas_pkg::word_t sum_bits
);
	`FAS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sum_bits))
	`FAS_ASSERT_IMPL(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`FAS_ASSERT_NEXT(a_full_holds, clk, arst_n, !in_ready, out_valid)
	`FAS_ASSERT_IMPL(a_drain_ready, clk, arst_n, out_valid && out_ready, in_ready)
endmodule
bind fp32_add_sub_core fp32_add_sub_core_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .sum_bits(sum_bits)
);
`default_nettype wire

### tb/sv/fp32_add_sub_core_tb.sv
// Self-checking testbench of the truncating single-precision add and subtract core.
`timescale 1ns / 1ps
module fp32_add_sub_core_tb;
	import fas_pkg::*;

	typedef struct packed {
		logic  op;
		word_t a;
		word_t b;
	} fp_item_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic func;
	word_t operand_a;
	word_t operand_b;
	logic out_valid;
	logic out_ready;
	word_t sum_bits;

	fp_item_t pending_ops[$];
	word_t expected_sums[$];
	int error_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	bit hold_off_out;
	bit hold_off_in;

	fp32_add_sub_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sum_bits(sum_bits)
	);

	function automatic word_t fp_add_same(word_t sgn, word_t ma, word_t mb);
		logic [7:0] ea, eb, et;
		logic [31:0] fa, fb, ft, m, e, sh;
		ea = ma[30:23];
		eb = mb[30:23];
		fa = {8'd0, 1'b1, ma[22:0]};
		fb = {8'd0, 1'b1, mb[22:0]};
		if (ea < eb) begin
			et = ea; ea = eb; eb = et;
			ft = fa; fa = fb; fb = ft;
		end
		sh = {24'd0, 8'(ea - eb)};
		if (sh > 31) sh = 31;
		m = fa + (fb >> sh);
		e = {24'd0, ea};
		if (m[24]) begin
			m = m >> 1;
			e = e + 1;
		end
		if (e >= 255) return sgn | INF_BITS;
		return sgn | (e << 23) | {9'd0, m[22:0]};
	endfunction

	function automatic word_t fp_sub_mag(word_t sgn_a, word_t ma, word_t sgn_b, word_t mb);
		logic [7:0] ea, eb, et;
		logic [31:0] fa, fb, ft, m, e, sh, sgn;
		ea = ma[30:23];
		eb = mb[30:23];
		fa = {8'd0, 1'b1, ma[22:0]};
		fb = {8'd0, 1'b1, mb[22:0]};
		sgn = sgn_a;
		if ((ea != eb) ? (eb > ea) : (fb > fa)) begin
			et = ea; ea = eb; eb = et;
			ft = fa; fa = fb; fb = ft;
			sgn = sgn_b;
		end
		sh = {24'd0, 8'(ea - eb)};
		if (sh > 31) sh = 31;
		m = fa - (fb >> sh);
		e = {24'd0, ea};
		while (!m[23] && e > 0) begin
			m = (m << 1) & 32'h00FF_FFFF;
			e = e - 1;
		end
		if (m == 0) return 32'd0;
		return sgn | (e << 23) | {9'd0, m[22:0]};
	endfunction

	function automatic word_t fp_sum(fp_item_t it);
		word_t b;
		b = it.b;
		if (it.op == FUNC_SUB) b[31] = ~b[31];
		if (it.a[30:0] == 0) return b;
		if (b[30:0] == 0) return it.a;
		if (it.a[31] == b[31])
			return fp_add_same({it.a[31], 31'd0}, {1'b0, it.a[30:0]}, {1'b0, b[30:0]});
		return fp_sub_mag({it.a[31], 31'd0}, {1'b0, it.a[30:0]}, {b[31], 31'd0},
			{1'b0, b[30:0]});
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR: %s at cycle %0d", what, cycle_count);
		error_count++;
	endtask

	task automatic push_op(logic op, word_t a, word_t b);
		fp_item_t it;
		it.op = op;
		it.a = a;
		it.b = b;
		pending_ops.push_back(it);
	endtask

	function automatic word_t rand_fp();
		word_t w;
		w = $urandom;
		case ($urandom_range(0, 5))
			0: w[30:23] = 8'($urandom_range(0, 3));
			1: w[30:23] = 8'($urandom_range(252, 255));
			2: w[30:0] = 31'd0;
			default: w[30:23] = 8'($urandom_range(110, 145));
		endcase
		return w;
	endfunction

	task automatic push_random(int n);
		word_t a, b;
		for (int i = 0; i < n; i++) begin
			a = rand_fp();
			b = rand_fp();
			if ($urandom_range(0, 3) == 0) begin
				b = a ^ ($urandom_range(0, 1) << 31);
				if ($urandom_range(0, 1)) b[$urandom_range(0, 22)] ^= 1'b1;
			end
			push_op(logic'($urandom_range(0, 1)), a, b);
		end
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || expected_sums.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) expected_sums.push_back(fp_sum({func, operand_a, operand_b}));
		if (!in_valid || in_ready) begin
			if (arst_n && !hold_off_in && pending_ops.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				func <= pending_ops[0].op;
				operand_a <= pending_ops[0].a;
				operand_b <= pending_ops[0].b;
				void'(pending_ops.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", sum_bits));
			end else begin
				if (sum_bits !== expected_sums[0])
					report_mismatch($sformatf("sum_bits %h, expected %h", sum_bits,
						expected_sums[0]));
				void'(expected_sums.pop_front());
			end
		end
		if (hold_off_out) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else begin
			out_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		func = FUNC_ADD;
		operand_a = '0;
		operand_b = '0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		hold_off_out = 1'b0;
		hold_off_in = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_op(FUNC_ADD, 32'h0000_0000, 32'h8000_0000);
		push_op(FUNC_SUB, 32'h8000_0000, 32'h0000_0000);
		push_op(FUNC_ADD, 32'h3F80_0000, 32'h0000_0000);
		push_op(FUNC_SUB, 32'h0000_0000, 32'h4040_0000);
		push_op(FUNC_ADD, 32'h3F80_0000, 32'h3F80_0000);
		push_op(FUNC_SUB, 32'h3F80_0000, 32'h3F80_0000);
		push_op(FUNC_ADD, 32'h3F80_0000, 32'hBF80_0000);
		push_op(FUNC_SUB, 32'h3F80_0000, 32'h4000_0000);
		push_op(FUNC_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
		push_op(FUNC_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF);
		push_op(FUNC_ADD, 32'h7F80_0000, 32'h7FC0_0001);
		push_op(FUNC_ADD, 32'h4B80_0000, 32'h0000_0001);
		push_op(FUNC_ADD, 32'h7F00_0000, 32'h0080_0000);
		push_op(FUNC_SUB, 32'h0080_0001, 32'h0080_0000);
		push_op(FUNC_SUB, 32'h0000_0002, 32'h0000_0001);
		push_op(FUNC_ADD, 32'h0000_0001, 32'h0000_0001);
		push_op(FUNC_SUB, 32'h3F80_0001, 32'h3F80_0000);
		push_op(FUNC_ADD, 32'hBF80_0000, 32'h3F80_0001);
		push_op(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(FUNC_SUB, 32'h7FFF_FFFF, 32'h8000_0001);
		drain();

		push_random(200);
		drain();
		send_idle_pct = 72;
		push_random(150);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 72;
		push_random(150);
		drain();
		send_idle_pct = 18;
		recv_stall_pct = 18;
		push_random(150);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_out = 1'b1;
		push_random(100);
		while (hold_cycles < 60) @(posedge clk);
		hold_off_out = 1'b0;
		drain();
		hold_off_in = 1'b1;
		repeat (20) @(posedge clk);
		hold_off_in = 1'b0;
		push_random(50);
		drain();

		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
